// ===== src/rabd_pkg.sv =====
// shared types and constants for the reduced-round block decryptor
// holds the item structs, config register indexes and the s-box tables
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rabd_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HI = 2'd0,
    CFG_KEY_LO = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } cipher_t;

  typedef struct packed {
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
  } plain_t;

  typedef logic [127:0]     state_t;
  typedef logic [3:0][31:0] rkey_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // column c of the round key covers state bytes 4c..4c+3, row 0 in the top byte
  function automatic state_t add_key(state_t s, rkey_t rk);
    return s ^ {rk[0], rk[1], rk[2], rk[3]};
  endfunction

endpackage

`default_nettype wire

// ===== src/reduced_aes_block_decrypt_top.sv =====
// top level of the reduced-round block decryptor
// depends on rabd_pkg, rabd_key_expand and rabd_round
//
// usage:
//   key: write key_hi (index 0) and key_lo (index 1) over the cfg channel
//   (cfg_valid_i / cfg_ready_o). a write rebuilds the round key schedule,
//   one column per cycle, which keeps busy_o high until the schedule is
//   complete. writes to other indexes are dropped.
//   items: a ciphertext block is taken at a clock edge where start_i is high
//   and busy_o is low. one item per cycle can be taken while the schedule
//   is ready; the round pipeline has one stage per round and never holds.
//   results: plain_o is valid for exactly one cycle with done_o high, in
//   order, after the input register, round stages and output register.
//   the receiver cannot stall, so nothing backs up.
//   reset: the key clears to zero and the schedule for the zero key is
//   built right after reset; busy_o stays high until it is done.
`timescale 1ns / 1ps
`default_nettype none

module reduced_aes_block_decrypt_top #(
  parameter int unsigned ROUND_COUNT = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire rabd_pkg::cipher_t             cipher_i,
  output logic                               done_o,
  output rabd_pkg::plain_t                   plain_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rabd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [63:0]                   cfg_data_i
);

  localparam int unsigned Cols = 4 * (ROUND_COUNT + 1);

  logic [Cols-1:0][31:0] rkeys;
  logic                  busy;

  logic                    vld  [ROUND_COUNT+1];
  rabd_pkg::state_t        st   [ROUND_COUNT+1];

  logic                    in_q;
  rabd_pkg::state_t        in_state_q;
  logic                    done_q;
  rabd_pkg::plain_t        plain_q;

  rabd_key_expand #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_key_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .rkeys_o     (rkeys)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= 1'b0;
    end else begin
      in_q <= start_i && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_state_q <= cipher_i;
  end

  assign vld[0] = in_q;
  assign st[0]  = in_state_q;

  // stage i applies round key ROUND_COUNT-i+1
  for (genvar i = 1; i <= ROUND_COUNT; i++) begin : g_round
    rabd_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i-1]),
      .state_i (st[i-1]),
      .rkey_i  (rkeys[4*(ROUND_COUNT-i+1) +: 4]),
      .valid_o (vld[i]),
      .state_o (st[i])
    );
  end

  // output register with the final add of round key 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk_i) begin
    plain_q <= rabd_pkg::add_key(st[ROUND_COUNT], rkeys[3:0]);
  end

  assign busy_o  = busy;
  assign done_o  = done_q;
  assign plain_o = plain_q;

endmodule

`default_nettype wire

// ===== src/rabd_key_expand.sv =====
// key registers and round key schedule, one new column per cycle
// depends on rabd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rabd_key_expand #(
  parameter int unsigned ROUND_COUNT = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [rabd_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  wire logic [63:0]                            cfg_data_i,
  output logic                                        busy_o,
  output logic [4*(ROUND_COUNT+1)-1:0][31:0]          rkeys_o
);

  localparam int unsigned Cols = 4 * (ROUND_COUNT + 1);
  localparam int unsigned ColW = $clog2(Cols);

  typedef enum logic [2:0] {
    KS_IDLE   = 3'b001,
    KS_LOAD   = 3'b010,
    KS_EXPAND = 3'b100
  } ks_state_e;

  ks_state_e             state_q, state_d;
  logic [63:0]           key_hi_q, key_lo_q;
  logic [ColW-1:0]       cnt_q, cnt_d;
  logic [3:0][31:0]      win_q;
  logic [Cols-1:0][31:0] rk_q;

  logic                  cfg_hit;
  logic [31:0]           rot_w, sub_w, new_w;
  logic [ColW-1:0]       grp;
  logic [7:0]            rcon;

  assign cfg_ready_o = (state_q == KS_IDLE);
  assign busy_o      = (state_q != KS_IDLE);
  assign rkeys_o     = rk_q;

  assign cfg_hit = cfg_valid_i && cfg_ready_o &&
                   ((cfg_index_i == rabd_pkg::CFG_KEY_HI) ||
                    (cfg_index_i == rabd_pkg::CFG_KEY_LO));

  // every new column gets rotword, subword and rcon
  always_comb begin
    rot_w = {win_q[3][23:0], win_q[3][31:24]};
    for (int r = 0; r < 4; r++) begin
      sub_w[31-8*r -: 8] = rabd_pkg::SBOX[rot_w[31-8*r -: 8]];
    end
    grp   = (cnt_q >> 2) - ColW'(1);
    rcon  = 8'h01 << grp[2:0];
    new_w = sub_w ^ {rcon, 24'h0} ^ win_q[0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      KS_IDLE: begin
        if (cfg_hit) state_d = KS_LOAD;
      end
      KS_LOAD: begin
        state_d = KS_EXPAND;
        cnt_d   = ColW'(4);
      end
      KS_EXPAND: begin
        cnt_d = cnt_q + ColW'(1);
        if (cnt_q == ColW'(Cols - 1)) state_d = KS_IDLE;
      end
      default: state_d = KS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= KS_LOAD;
      cnt_q    <= ColW'(4);
      key_hi_q <= 64'h0;
      key_lo_q <= 64'h0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_hit && (cfg_index_i == rabd_pkg::CFG_KEY_HI)) key_hi_q <= cfg_data_i;
      if (cfg_hit && (cfg_index_i == rabd_pkg::CFG_KEY_LO)) key_lo_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == KS_LOAD) begin
      win_q   <= {key_lo_q[31:0], key_lo_q[63:32], key_hi_q[31:0], key_hi_q[63:32]};
      rk_q[0] <= key_hi_q[63:32];
      rk_q[1] <= key_hi_q[31:0];
      rk_q[2] <= key_lo_q[63:32];
      rk_q[3] <= key_lo_q[31:0];
    end else if (state_q == KS_EXPAND) begin
      win_q       <= {new_w, win_q[3], win_q[2], win_q[1]};
      rk_q[cnt_q] <= new_w;
    end
  end

endmodule

`default_nettype wire

// ===== src/rabd_round.sv =====
// one registered decryption round: add round key, inverse shift rows, inverse s-box
// depends on rabd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rabd_round (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire rabd_pkg::state_t state_i,
  input  wire rabd_pkg::rkey_t  rkey_i,
  output logic                  valid_o,
  output rabd_pkg::state_t      state_o
);

  rabd_pkg::state_t keyed, state_d, state_q;
  logic             valid_q;

  // byte b sits at row b%4, column b/4; row r is rotated right by r columns
  always_comb begin
    keyed = rabd_pkg::add_key(state_i, rkey_i);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        state_d[127-8*(r+4*c) -: 8] =
          rabd_pkg::INV_SBOX[keyed[127-8*(r+4*((c+4-r)%4)) -: 8]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

`default_nettype wire

// ===== src/rabd_checker.sv =====
// port-level checks for the reduced-round block decryptor
// depends on rabd_pkg; bound to reduced_aes_block_decrypt_top
`timescale 1ns / 1ps
`default_nettype none

module rabd_checker #(
  parameter int unsigned ROUND_COUNT = 8
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic                          done_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [rabd_pkg::CfgIdxW-1:0]  cfg_index_i
);

  localparam int unsigned Latency   = ROUND_COUNT + 2;
  localparam int unsigned BusyCycles = 4 * (ROUND_COUNT + 1) - 3;

  // every taken item shows up exactly once after the pipeline latency
  // ticks from before the start of simulation read as unknown, so count as no item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == ($past(start_i && !busy_o, Latency) === 1'b1))
    else $error("result strobe does not match item taken %0d cycles earlier", Latency);

  // a key write starts a schedule rebuild
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o &&
     ((cfg_index_i == rabd_pkg::CFG_KEY_HI) || (cfg_index_i == rabd_pkg::CFG_KEY_LO)))
    |=> busy_o)
    else $error("key write did not start the schedule rebuild");

  // no key write taken while the schedule is rebuilt
  a_busy_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cfg_ready_o)
    else $error("config taken during schedule rebuild");

  // a rebuild runs its full length
  a_busy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(busy_o, BusyCycles))
    else $error("schedule rebuild ended early");

endmodule

bind reduced_aes_block_decrypt_top rabd_checker #(
  .ROUND_COUNT (ROUND_COUNT)
) u_rabd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i)
);

`default_nettype wire
